[hw/rtl/cif_pkg.sv]
// cif_pkg: types, stage map and per-stage step logic of the contact impulse pipeline.
// Depends on nothing; used by contact_impulse_with_friction.
package cif_pkg;

	// Fixed-point format and limits
	localparam int FRAC_BITS    = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int MAX_CONTACTS = 8;
	localparam int ONE_Q        = 1 << FRAC_BITS;
	localparam logic signed [33:0] EPS_Q = 34'((ONE_Q + 500) / 1000);
	localparam logic signed [69:0] SAT_HI = (70'sd1 <<< (DATA_WIDTH - 1)) - 70'sd1;
	localparam logic signed [69:0] SAT_LO = -SAT_HI - 70'sd1;

	// Iteration counts of the shared step units
	localparam int SQ_STEPS  = 32;          // 64-bit integer root, two bits per step
	localparam int MU_STEPS  = 18;          // 36-bit root of fa*fb
	localparam int MU_FIRST  = SQ_STEPS - MU_STEPS;
	localparam int DIV_STEPS = 54;          // restoring divide, 54-bit dividend

	// Stage map
	localparam int K_MUL   = 1;
	localparam int K_MAG   = 2;
	localparam int K_LSQ   = 3;
	localparam int K_LEN   = K_LSQ + SQ_STEPS;
	localparam int K_NDV   = K_LEN + 1;
	localparam int K_UN    = K_NDV + DIV_STEPS;
	localparam int K_VP    = K_UN + 1;
	localparam int K_VN    = K_UN + 2;
	localparam int K_PN    = K_UN + 3;
	localparam int K_NUM   = K_UN + 4;
	localparam int K_TSQ   = K_NUM + 1;
	localparam int K_TMAG  = K_NUM + 2;
	localparam int K_JDV   = K_TMAG;
	localparam int K_J     = K_JDV + DIV_STEPS;
	localparam int K_IX    = K_J + 1;
	localparam int K_TSQS  = K_TMAG + 1;
	localparam int K_TLEN  = K_TSQS + SQ_STEPS;
	localparam int K_TDV   = K_TLEN + 1;
	localparam int K_UT    = K_TDV + DIV_STEPS;
	localparam int K_VTP   = K_UT + 1;
	localparam int K_VT    = K_UT + 2;
	localparam int K_JTI   = K_UT + 3;
	localparam int K_JTDV  = K_JTI + 1;
	localparam int K_JTP   = K_JTDV + DIV_STEPS;
	localparam int K_JT    = K_JTP + 1;
	localparam int K_TIX   = K_JTP + 2;
	localparam int K_DP    = K_JTP + 3;
	localparam int K_OUT   = K_JTP + 4;
	localparam int NUM_STAGES = K_OUT;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] r;
	} sq_t;

	typedef struct packed {
		logic                sat;
		logic signed [31:0]  v;
	} sat_t;

	typedef struct packed {
		logic signed [31:0] vx, vy, nx, ny;
		logic [30:0]        ima, imb;
		logic [16:0]        ra, rb;
		logic [17:0]        fa, fb;
		logic [3:0]         cnt, cntc;
		logic [17:0]        ope;
		logic [31:0]        msum;
		logic [35:0]        dv;
		logic [35:0]        ff;
		logic [63:0]        nx2, ny2;
		logic [63:0]        sq_x, sq_r, mu_x, mu_r;
		logic [31:0]        len, tlen;
		logic [90:0]        acc_a, acc_b, acc_j;
		logic signed [17:0] unx, uny;
		logic signed [51:0] pa, pb;
		logic signed [33:0] vn;
		logic               sep;
		logic signed [52:0] pn;
		logic signed [51:0] ptx, pty;
		logic signed [37:0] num;
		logic signed [36:0] tx, ty;
		logic               tovf;
		logic               jneg;
		logic signed [31:0] j;
		logic               sat;
		logic signed [33:0] ix, iy;
		logic signed [34:0] lim;
		logic signed [19:0] utx, uty;
		logic signed [35:0] vt;
		logic signed [54:0] jtc;
		logic signed [31:0] jt;
		logic signed [35:0] tix, tiy;
		logic signed [65:0] mxa, mya, mxb, myb;
		logic signed [67:0] txa, tya, txb, tyb;
		logic signed [31:0] dax, day, dbx, dby;
	} item_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [37:0] abs38(input logic signed [37:0] v);
		return v[37] ? 38'(-v) : 38'(v);
	endfunction

	function automatic sat_t clip(input logic signed [69:0] v);
		sat_t c;
		c.sat = 1'b0;
		if (v > SAT_HI) begin
			c.sat = 1'b1;
			c.v   = 32'(SAT_HI);
		end else if (v < SAT_LO) begin
			c.sat = 1'b1;
			c.v   = 32'(SAT_LO);
		end else begin
			c.v   = 32'(v);
		end
		return c;
	endfunction

	// One iteration of the digit-by-digit root; i selects the bit pair
	function automatic sq_t sqrt_step(input logic [63:0] x, input logic [63:0] r,
			input logic [4:0] i);
		sq_t        o;
		logic [63:0] bitv;
		logic [64:0] t;
		bitv = 64'd1 << (6'd62 - {i, 1'b0});
		t    = {1'b0, r} + {1'b0, bitv};
		if ({1'b0, x} >= t) begin
			o.x = x - t[63:0];
			o.r = (r >> 1) + bitv;
		end else begin
			o.x = x;
			o.r = r >> 1;
		end
		return o;
	endfunction

	// One restoring divide step: acc = {remainder[36:0], dividend/quotient[53:0]}
	function automatic logic [90:0] div_step(input logic [90:0] a, input logic [35:0] d);
		logic [90:0] sh;
		logic [36:0] r;
		sh = {a[89:0], 1'b0};
		r  = sh[90:54];
		if (r >= {1'b0, d}) begin
			sh[90:54] = r - {1'b0, d};
			sh[0]     = 1'b1;
		end
		return sh;
	endfunction

	// Work done by pipeline stage k on the item it holds
	function automatic item_t stage_step(input int k, input item_t s);
		item_t              n;
		logic [31:0]        ax, ay;
		logic [37:0]        bx, by;
		logic [16:0]        emin;
		logic [64:0]        msq;
		logic signed [54:0] jw, lim_w;
		sat_t               c0, c1, c2, c3;
		sq_t                sq;
		logic [4:0]         i;
		n = s;
		if (k == K_MUL) begin
			ax = abs32(s.nx);
			ay = abs32(s.ny);
			n.nx2  = 64'(ax) * 64'(ax);
			n.ny2  = 64'(ay) * 64'(ay);
			n.ff   = 36'(s.fa) * 36'(s.fb);
			n.msum = 32'(s.ima) + 32'(s.imb);
			emin = (s.ra < s.rb) ? s.ra : s.rb;
			if (emin > 17'(ONE_Q))
				emin = 17'(ONE_Q);
			n.ope = 18'(ONE_Q) + 18'(emin);
			if (s.cnt > 4'(MAX_CONTACTS))
				n.cntc = 4'(MAX_CONTACTS);
			else if (s.cnt == 4'd0)
				n.cntc = 4'd1;
			else
				n.cntc = s.cnt;
		end
		if (k == K_MAG) begin
			n.sq_x = s.nx2 + s.ny2;
			n.sq_r = '0;
			n.mu_x = 64'(s.ff);
			n.mu_r = '0;
			n.dv   = 36'(s.msum) * 36'(s.cntc);
		end
		if (k inside {[K_LSQ:K_LEN-1]}) begin
			i  = 5'(k - K_LSQ);
			sq = sqrt_step(s.sq_x, s.sq_r, i);
			n.sq_x = sq.x;
			n.sq_r = sq.r;
			if (i >= 5'(MU_FIRST)) begin
				sq = sqrt_step(s.mu_x, s.mu_r, i);
				n.mu_x = sq.x;
				n.mu_r = sq.r;
			end
		end
		if (k == K_LEN) begin
			ax = abs32(s.nx);
			ay = abs32(s.ny);
			n.len   = s.sq_r[31:0];
			n.acc_a = {37'd0, 54'(ax) << FRAC_BITS};
			n.acc_b = {37'd0, 54'(ay) << FRAC_BITS};
		end
		if (k inside {[K_NDV:K_UN-1]}) begin
			n.acc_a = div_step(s.acc_a, 36'(s.len));
			n.acc_b = div_step(s.acc_b, 36'(s.len));
		end
		if (k == K_UN) begin
			// |n| <= len, so the unit components fit 17 magnitude bits
			n.unx = s.nx[31] ? -$signed({1'b0, s.acc_a[16:0]}) : $signed({1'b0, s.acc_a[16:0]});
			n.uny = s.ny[31] ? -$signed({1'b0, s.acc_b[16:0]}) : $signed({1'b0, s.acc_b[16:0]});
			n.sep = (s.len == '0);
		end
		if (k == K_VP) begin
			n.pa = 52'(s.vx * s.unx);
			n.pb = 52'(s.vy * s.uny);
		end
		if (k == K_VN)
			n.vn = 34'((s.pa + s.pb) >>> FRAC_BITS);
		if (k == K_PN) begin
			n.sep = s.sep | (s.vn > EPS_Q);
			n.pn  = 53'($signed({1'b0, s.ope}) * s.vn);
			n.ptx = 52'(s.unx * s.vn);
			n.pty = 52'(s.uny * s.vn);
		end
		if (k == K_NUM) begin
			n.num = -38'(s.pn >>> FRAC_BITS);
			n.tx  = 37'(s.vx) - 37'(s.ptx >>> FRAC_BITS);
			n.ty  = 37'(s.vy) - 37'(s.pty >>> FRAC_BITS);
		end
		if (k == K_TSQ) begin
			bx = abs38(s.num);
			n.acc_j = {37'd0, 54'(bx) << FRAC_BITS};
			n.jneg  = s.num[37];
			bx = abs38(38'(s.tx));
			by = abs38(38'(s.ty));
			n.tovf = (bx[37:32] != '0) || (by[37:32] != '0);
			n.nx2  = 64'(bx[31:0]) * 64'(bx[31:0]);
			n.ny2  = 64'(by[31:0]) * 64'(by[31:0]);
		end
		if (k == K_TMAG) begin
			msq = 65'(s.nx2) + 65'(s.ny2);
			n.sq_x = (s.tovf || msq[64]) ? '1 : msq[63:0];
			n.sq_r = '0;
		end
		if (k inside {[K_JDV:K_J-1]})
			n.acc_j = div_step(s.acc_j, s.dv);
		if (k inside {[K_TSQS:K_TLEN-1]}) begin
			i  = 5'(k - K_TSQS);
			sq = sqrt_step(s.sq_x, s.sq_r, i);
			n.sq_x = sq.x;
			n.sq_r = sq.r;
		end
		if (k == K_TLEN) begin
			bx = abs38(38'(s.tx));
			by = abs38(38'(s.ty));
			n.tlen  = s.sq_r[31:0];
			n.acc_a = {37'd0, 54'(bx) << FRAC_BITS};
			n.acc_b = {37'd0, 54'(by) << FRAC_BITS};
		end
		if (k inside {[K_TDV:K_UT-1]}) begin
			n.acc_a = div_step(s.acc_a, 36'(s.tlen));
			n.acc_b = div_step(s.acc_b, 36'(s.tlen));
		end
		if (k == K_J) begin
			jw = s.jneg ? -$signed({1'b0, s.acc_j[53:0]}) : $signed({1'b0, s.acc_j[53:0]});
			if (s.msum == '0)
				jw = '0;
			c0 = clip(70'(jw));
			n.j   = c0.v;
			n.sat = c0.sat;
		end
		if (k == K_IX) begin
			// full-width products before the shift
			n.ix  = 34'((50'(s.unx) * 50'(s.j)) >>> FRAC_BITS);
			n.iy  = 34'((50'(s.uny) * 50'(s.j)) >>> FRAC_BITS);
			n.lim = 35'((51'(s.j) * 51'($signed({1'b0, s.mu_r[17:0]}))) >>> FRAC_BITS);
		end
		if (k == K_UT) begin
			n.utx = s.tx[36] ? -$signed({1'b0, s.acc_a[18:0]}) : $signed({1'b0, s.acc_a[18:0]});
			n.uty = s.ty[36] ? -$signed({1'b0, s.acc_b[18:0]}) : $signed({1'b0, s.acc_b[18:0]});
		end
		if (k == K_VTP) begin
			n.pa = 52'(s.vx * s.utx);
			n.pb = 52'(s.vy * s.uty);
		end
		if (k == K_VT)
			n.vt = 36'((s.pa + s.pb) >>> FRAC_BITS);
		if (k == K_JTI) begin
			bx = abs38(38'(s.vt));
			n.acc_j = {37'd0, 54'(bx) << FRAC_BITS};
			n.jneg  = !s.vt[35] && (s.vt != '0);
		end
		if (k inside {[K_JTDV:K_JTP-1]})
			n.acc_j = div_step(s.acc_j, s.dv);
		if (k == K_JTP) begin
			jw    = s.jneg ? -$signed({1'b0, s.acc_j[53:0]}) : $signed({1'b0, s.acc_j[53:0]});
			lim_w = 55'(s.lim);
			if (jw > lim_w)
				n.jtc = lim_w;
			else if (jw < -lim_w)
				n.jtc = -lim_w;
			else
				n.jtc = jw;
		end
		if (k == K_JT) begin
			if (s.num != '0 && s.msum != '0 && s.tlen != '0) begin
				c0 = clip(70'(s.jtc));
				n.jt  = c0.v;
				n.sat = s.sat | c0.sat;
			end else begin
				n.jt = '0;
			end
		end
		if (k == K_TIX) begin
			n.tix = 36'((52'(s.utx) * 52'(s.jt)) >>> FRAC_BITS);
			n.tiy = 36'((52'(s.uty) * 52'(s.jt)) >>> FRAC_BITS);
		end
		if (k == K_DP) begin
			n.mxa = 66'(s.ix * $signed({1'b0, s.ima}));
			n.mya = 66'(s.iy * $signed({1'b0, s.ima}));
			n.mxb = 66'(s.ix * $signed({1'b0, s.imb}));
			n.myb = 66'(s.iy * $signed({1'b0, s.imb}));
			n.txa = 68'(s.tix * $signed({1'b0, s.ima}));
			n.tya = 68'(s.tiy * $signed({1'b0, s.ima}));
			n.txb = 68'(s.tix * $signed({1'b0, s.imb}));
			n.tyb = 68'(s.tiy * $signed({1'b0, s.imb}));
		end
		if (k == K_OUT) begin
			c0 = clip(-70'(s.mxa >>> FRAC_BITS) - 70'(s.txa >>> FRAC_BITS));
			c1 = clip(-70'(s.mya >>> FRAC_BITS) - 70'(s.tya >>> FRAC_BITS));
			c2 = clip(70'(s.mxb >>> FRAC_BITS) + 70'(s.txb >>> FRAC_BITS));
			c3 = clip(70'(s.myb >>> FRAC_BITS) + 70'(s.tyb >>> FRAC_BITS));
			if (s.sep) begin
				n.dax = '0;
				n.day = '0;
				n.dbx = '0;
				n.dby = '0;
				n.sat = 1'b0;
			end else begin
				n.dax = c0.v;
				n.day = c1.v;
				n.dbx = c2.v;
				n.dby = c3.v;
				n.sat = s.sat | c0.sat | c1.sat | c2.sat | c3.sat;
			end
		end
		return n;
	endfunction

endpackage

[hw/rtl/contact_impulse_with_friction.sv]
// contact_impulse_with_friction: top level, a single deep pipeline over cif_pkg::stage_step.
// Depends on cif_pkg.
//
// Impulse response with Coulomb friction for one contact pair per item, signed Q16.16.
// The block takes one item every clock cycle unless out_stall holds the output item. The input
// register loads at the accepting edge, and the result then passes one more register per
// stage, 246 stages, to the output register. The depth is set by the chain of
// units on the critical path: a 32-step root for the normal length, a 54-step divide for
// the unit normal, a 32-step root and a 54-step divide for the unit tangent, and a
// 54-step divide for the friction impulse; the normal impulse divide and the friction
// root run beside them. Each stage holds a root or divide step, or a layer of multiply, add or clip logic.
// The pipeline moves as a whole: when the output item is held by out_stall, every stage
// holds and in_stall is raised, so nothing is lost or repeated. No reset sweep is needed.

module contact_impulse_with_friction (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  rel_vel_x,
	input  logic signed [31:0]  rel_vel_y,
	input  logic signed [31:0]  normal_x,
	input  logic signed [31:0]  normal_y,
	input  logic [30:0]         inv_mass_a,
	input  logic [30:0]         inv_mass_b,
	input  logic [16:0]         restitution_a,
	input  logic [16:0]         restitution_b,
	input  logic [17:0]         friction_a,
	input  logic [17:0]         friction_b,
	input  logic [3:0]          contact_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  delta_va_x,
	output logic signed [31:0]  delta_va_y,
	output logic signed [31:0]  delta_vb_x,
	output logic signed [31:0]  delta_vb_y,
	output logic                separating,
	output logic                saturated
);
	import cif_pkg::*;

	// pipe_s[0] is the input register; pipe_s[NUM_STAGES] is the output register
	item_t               pipe_s [NUM_STAGES+1];
	logic [NUM_STAGES:0] vld_s;
	item_t               in_item;
	logic                adv;

	// Whole pipeline advances unless a finished item is being held downstream
	assign adv      = !(vld_s[NUM_STAGES] && out_stall);
	assign in_stall = !adv;

	always_comb begin
		in_item     = '0;
		in_item.vx  = rel_vel_x;
		in_item.vy  = rel_vel_y;
		in_item.nx  = normal_x;
		in_item.ny  = normal_y;
		in_item.ima = inv_mass_a;
		in_item.imb = inv_mass_b;
		in_item.ra  = restitution_a;
		in_item.rb  = restitution_b;
		in_item.fa  = friction_a;
		in_item.fb  = friction_b;
		in_item.cnt = contact_count;
	end

	// Valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-1:0], in_valid};
		end
	end

	// Datapath: each stage applies its own fixed step to the item it receives
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= in_item;
			for (int k = 1; k <= NUM_STAGES; k++)
				pipe_s[k] <= stage_step(k, pipe_s[k-1]);
		end
	end

	assign out_valid  = vld_s[NUM_STAGES];
	assign delta_va_x = pipe_s[NUM_STAGES].dax;
	assign delta_va_y = pipe_s[NUM_STAGES].day;
	assign delta_vb_x = pipe_s[NUM_STAGES].dbx;
	assign delta_vb_y = pipe_s[NUM_STAGES].dby;
	assign separating = pipe_s[NUM_STAGES].sep;
	assign saturated  = pipe_s[NUM_STAGES].sat;

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for contact_impulse_with_friction.
// Depends on cif_pkg and the block RTL; holds its own fixed-point impulse predictor.
`timescale 1ns / 1ps

module testbench;
	import cif_pkg::*;

	localparam int RAND_ITEMS  = 800;
	localparam int QUIET_ITEMS = 100;    // last items run with no idling on either side
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 300;    // idle wait after the last expected result
	localparam int HOLD_CYCLES = 600;    // long receiver hold, well over the pipe depth
	localparam logic signed [127:0] ONE_FX  = 128'sd65536;
	localparam logic signed [127:0] EPS_FX  = 128'sd66;
	localparam logic signed [127:0] MAX_OUT = 128'sd2147483647;
	localparam logic signed [127:0] MIN_OUT = -128'sd2147483648;

	typedef struct {
		logic signed [31:0] vx, vy, nx, ny;
		logic [30:0]        ima, imb;
		logic [16:0]        ra, rb;
		logic [17:0]        fa, fb;
		logic [3:0]         cnt;
	} pair_t;

	typedef struct {
		logic signed [31:0] dax, day, dbx, dby;
		logic               sep, sat;
	} resp_t;

	typedef struct {
		pair_t p;
		bit    fixed;   // expected result typed in below, not predicted
		resp_t r;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] rel_vel_x, rel_vel_y, normal_x, normal_y;
	logic [30:0] inv_mass_a, inv_mass_b;
	logic [16:0] restitution_a, restitution_b;
	logic [17:0] friction_a, friction_b;
	logic [3:0]  contact_count;
	logic signed [31:0] delta_va_x, delta_va_y, delta_vb_x, delta_vb_y;
	logic separating, saturated;

	resp_t pending_q[$];
	int    mismatches = 0;
	int    cycles = 0;
	bit    quiet = 0;
	bit    hold_req = 0;

	contact_impulse_with_friction dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor root of the squared length; the squared length is pinned to all ones when it cannot be held in 64 bits
	function automatic logic signed [127:0] length_of(input logic signed [127:0] a,
			input logic signed [127:0] b);
		logic [127:0] ua, ub, s;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		if (ua > 128'hFFFFFFFF || ub > 128'hFFFFFFFF)
			s = 128'hFFFFFFFF_FFFFFFFF;
		else begin
			s = ua * ua + ub * ub;
			if (s > 128'hFFFFFFFF_FFFFFFFF)
				s = 128'hFFFFFFFF_FFFFFFFF;
		end
		return $signed({64'd0, root_floor(s[63:0])});
	endfunction

	function automatic logic signed [127:0] fx_shr(input logic signed [127:0] v);
		return v >>> 16;
	endfunction

	function automatic logic signed [127:0] pin32(input logic signed [127:0] v,
			inout logic flag);
		if (v > MAX_OUT) begin
			flag = 1;
			return MAX_OUT;
		end
		if (v < MIN_OUT) begin
			flag = 1;
			return MIN_OUT;
		end
		return v;
	endfunction

	function automatic resp_t impulse_of(input pair_t p);
		resp_t r;
		logic signed [127:0] vx, vy, nx, ny, ima, imb, ra, rb, fa, fb, cnt, msum;
		logic signed [127:0] len, unx, uny, vn, e, num, j, ix, iy, tix, tiy;
		logic signed [127:0] tx, ty, tlen, utx, uty, vt, jt, mu, lim;
		logic flag;
		vx = p.vx; vy = p.vy; nx = p.nx; ny = p.ny;
		ima = $signed({97'd0, p.ima}); imb = $signed({97'd0, p.imb});
		ra = $signed({111'd0, p.ra}); rb = $signed({111'd0, p.rb});
		fa = $signed({110'd0, p.fa}); fb = $signed({110'd0, p.fb});
		cnt = $signed({124'd0, p.cnt});
		msum = ima + imb;
		flag = 0;
		j = 0; tix = 0; tiy = 0;
		r = '{default: 0};
		r.sep = 1;
		if (cnt > 8)
			cnt = 8;
		len = length_of(nx, ny);
		if (len == 0)
			return r;
		unx = nx * ONE_FX / len;
		uny = ny * ONE_FX / len;
		vn = fx_shr(vx * unx + vy * uny);
		if (vn > EPS_FX)
			return r;
		e = ra < rb ? ra : rb;
		if (e > ONE_FX)
			e = ONE_FX;
		num = -fx_shr((ONE_FX + e) * vn);
		if (msum != 0)
			j = num * ONE_FX / msum;
		if (cnt > 0 && j != 0)
			j = j / cnt;
		j = pin32(j, flag);
		ix = fx_shr(unx * j);
		iy = fx_shr(uny * j);
		if (num != 0 && msum != 0) begin
			tx = vx - fx_shr(unx * vn);
			ty = vy - fx_shr(uny * vn);
			tlen = length_of(tx, ty);
			if (tlen != 0) begin
				utx = tx * ONE_FX / tlen;
				uty = ty * ONE_FX / tlen;
				vt = fx_shr(vx * utx + vy * uty);
				jt = -vt * ONE_FX / msum;
				mu = $signed({64'd0, root_floor(64'(p.fa) * 64'(p.fb))});
				if (cnt > 0 && jt != 0)
					jt = jt / cnt;
				lim = fx_shr(j * mu);
				if (jt > lim)
					jt = lim;
				else if (jt < -lim)
					jt = -lim;
				jt = pin32(jt, flag);
				tix = fx_shr(utx * jt);
				tiy = fx_shr(uty * jt);
			end
		end
		r.sep = 0;
		r.dax = 32'(pin32(-fx_shr(ix * ima) - fx_shr(tix * ima), flag));
		r.day = 32'(pin32(-fx_shr(iy * ima) - fx_shr(tiy * ima), flag));
		r.dbx = 32'(pin32(fx_shr(ix * imb) + fx_shr(tix * imb), flag));
		r.dby = 32'(pin32(fx_shr(iy * imb) + fx_shr(tiy * imb), flag));
		r.sat = flag;
		return r;
	endfunction

	// ---------------- stimulus ----------------

	// mostly pairs of moderate size; the rest spans every bit
	function automatic pair_t random_pair();
		pair_t p;
		if ($urandom_range(0, 9) < 6) begin
			p.vx  = $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
			p.vy  = $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
			p.nx  = $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
			p.ny  = $signed(32'($urandom_range(0, 1 << 19))) - (1 << 18);
			p.ima = $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom_range(1, 1 << 18));
			p.imb = $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom_range(1, 1 << 18));
			p.ra  = 17'($urandom_range(0, 65536));
			p.rb  = 17'($urandom_range(0, 65536));
			p.fa  = 18'($urandom_range(0, 131072));
			p.fb  = 18'($urandom_range(0, 131072));
			p.cnt = 4'($urandom_range(0, 8));
		end else begin
			p.vx  = $urandom; p.vy = $urandom;
			p.nx  = $urandom; p.ny = $urandom;
			p.ima = 31'($urandom); p.imb = 31'($urandom);
			p.ra  = 17'($urandom); p.rb = 17'($urandom);
			p.fa  = 18'($urandom); p.fb = 18'($urandom);
			p.cnt = 4'($urandom);
		end
		return p;
	endfunction

	task automatic offer(input pair_t p, input bit fixed, input resp_t fx);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		rel_vel_x     <= p.vx;
		rel_vel_y     <= p.vy;
		normal_x      <= p.nx;
		normal_y      <= p.ny;
		inv_mass_a    <= p.ima;
		inv_mass_b    <= p.imb;
		restitution_a <= p.ra;
		restitution_b <= p.rb;
		friction_a    <= p.fa;
		friction_b    <= p.fb;
		contact_count <= p.cnt;
		in_valid      <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_q.push_back(fixed ? fx : impulse_of(p));
	endtask

	row_t  rows[$];
	resp_t sep_res;

	function automatic pair_t mk(input logic signed [31:0] vx, vy, nx, ny,
			input logic [30:0] ima, imb, input logic [16:0] ra, rb,
			input logic [17:0] fa, fb, input logic [3:0] cnt);
		pair_t p;
		p.vx = vx; p.vy = vy; p.nx = nx; p.ny = ny;
		p.ima = ima; p.imb = imb; p.ra = ra; p.rb = rb;
		p.fa = fa; p.fb = fb; p.cnt = cnt;
		return p;
	endfunction

	initial begin
		arst_n        = 0;
		in_valid      <= 0;
		rel_vel_x     <= 0; rel_vel_y <= 0; normal_x <= 0; normal_y <= 0;
		inv_mass_a    <= 0; inv_mass_b <= 0;
		restitution_a <= 0; restitution_b <= 0;
		friction_a    <= 0; friction_b <= 0;
		contact_count <= 0;
		sep_res = '{default: 0};
		sep_res.sep = 1;

		// zero normal counts as separating
		rows.push_back('{mk(-65536, 0, 0, 0, 65536, 65536, 0, 0, 0, 0, 1), 1, sep_res});
		// normal along x: vn equals vx; just over the threshold separates
		rows.push_back('{mk(67, 0, 65536, 0, 65536, 65536, 0, 0, 0, 0, 1), 1, sep_res});
		rows.push_back('{mk(66, 0, 65536, 0, 65536, 65536, 0, 0, 0, 0, 1), 0, sep_res});
		rows.push_back('{mk(32'sh7FFFFFFF, 0, 65536, 0, 1, 1, 0, 0, 0, 0, 0), 1, sep_res});
		// head-on, perfectly elastic, equal masses
		rows.push_back('{mk(-65536, 0, 65536, 0, 65536, 65536, 65536, 65536,
			0, 0, 1), 0, sep_res});
		// restitution above 1.0 gets capped
		rows.push_back('{mk(-65536, 0, 65536, 0, 65536, 65536, 17'h1FFFF, 17'h1FFFF,
			0, 0, 1), 0, sep_res});
		// both immovable: no impulse, no friction
		rows.push_back('{mk(-65536, 30000, 65536, 0, 0, 0, 65536, 65536,
			65536, 65536, 1), 0, sep_res});
		// velocity along the normal: zero tangent
		rows.push_back('{mk(-65536, -65536, 65536, 65536, 65536, 65536, 0, 0,
			131072, 131072, 2), 0, sep_res});
		// moving away along the normal: separates
		rows.push_back('{mk(0, 65536, 0, 65536 * 3, 65536, 65536, 0, 0,
			65536, 65536, 1), 0, sep_res});
		// slow separation under threshold gives negative j
		rows.push_back('{mk(40, 65536, 65536, 0, 65536, 65536, 0, 0,
			65536, 65536, 1), 0, sep_res});
		// sliding with friction, counts zero, max and over max
		rows.push_back('{mk(-65536, 200000, 65536, 0, 32768, 65536, 30000, 40000,
			131072, 131072, 0), 0, sep_res});
		rows.push_back('{mk(-65536, 200000, 65536, 0, 32768, 65536, 30000, 40000,
			131072, 131072, 8), 0, sep_res});
		rows.push_back('{mk(-65536, 200000, 65536, 0, 32768, 65536, 30000, 40000,
			18'h3FFFF, 18'h3FFFF, 4'hF), 0, sep_res});
		// field extremes, saturating paths
		rows.push_back('{mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 17'h1FFFF, 17'h1FFFF, 18'h3FFFF, 18'h3FFFF,
			4'hF), 0, sep_res});
		rows.push_back('{mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
			31'h7FFFFFFF, 0, 65536, 0, 131072, 0, 1), 0, sep_res});
		rows.push_back('{mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			1, 1, 0, 65536, 131072, 131072, 1), 0, sep_res});
		rows.push_back('{mk(-1, 0, 1, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0,
			0, 0, 8), 0, sep_res});

		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			offer(rows[i].p, rows[i].fixed, rows[i].r);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// receiver holds off while items keep coming, so the pipe fills
			if (n == 200)
				hold_req = 1;
			// sender pauses until every result is back
			if (n == 450) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			if (n == RAND_ITEMS - QUIET_ITEMS)
				quiet = 1;
			offer(random_pair(), 0, sep_res);
		end
		in_valid <= 0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ---------------- receiver side ----------------

	initial begin
		out_stall <= 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item");
			end else begin
				want = pending_q.pop_front();
				if (delta_va_x !== want.dax || delta_va_y !== want.day ||
						delta_vb_x !== want.dbx || delta_vb_y !== want.dby ||
						separating !== want.sep || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp va=(%0d,%0d) vb=(%0d,%0d) sep=%b sat=%b",
							" got va=(%0d,%0d) vb=(%0d,%0d) sep=%b sat=%b"},
							want.dax, want.day, want.dbx, want.dby, want.sep, want.sat,
							delta_va_x, delta_va_y, delta_vb_x, delta_vb_y,
							separating, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
